>>> rtl/ghalloc_pkg.sv
// Shared types and constants of the generational handle allocator.
package ghalloc_pkg;

   localparam int IDX_FIELD_W  = 6;
   localparam int GEN_FIELD_W  = 16;
   localparam int FUNC_FIELD_W = 3;
   localparam int GROUP_W      = 8;

   typedef enum logic [FUNC_FIELD_W-1:0] {
      FN_CREATE = 3'd0,
      FN_UPDATE = 3'd1,
      FN_REMOVE = 3'd2,
      FN_LOOKUP = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FIND,
      ST_EXEC,
      ST_CLEAR,
      ST_CLEAR_LAST,
      ST_DONE
   } state_type;

endpackage

>>> rtl/ghalloc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ghalloc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ghalloc_search.sv
// Two-level search for the lowest free slot: a registered group pick, then a bit pick.
module ghalloc_search #(
   parameter int SLOT_COUNT = 64,
   parameter int IDX_W      = 6
) (
   input  logic                  clock,
   input  logic [SLOT_COUNT-1:0] occ,
   output logic [IDX_W-1:0]      slot,
   output logic                  found
);

   localparam int GW8  = ghalloc_pkg::GROUP_W;
   localparam int NGRP = (SLOT_COUNT + GW8 - 1) / GW8;
   localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PADW = NGRP * GW8;

   logic [PADW-1:0]  taken;
   logic [GW-1:0]    grp_in;
   logic             grp_found_in;
   logic [GW-1:0]    grp_ff;
   logic             grp_found_ff;
   logic [GW8-1:0]   octet;
   logic [2:0]       bit_sel;
   logic [GW+2:0]    slot_wide;

   always_comb begin
      taken = '1;
      taken[SLOT_COUNT-1:0] = occ;
      taken[0] = 1'b1;
   end

   always_comb begin
      grp_in = '0;
      grp_found_in = 1'b0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (!(&taken[g*GW8 +: GW8])) begin
            grp_in = GW'(g);
            grp_found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff       <= grp_in;
      grp_found_ff <= grp_found_in;
   end

   always_comb begin
      octet = taken[{grp_ff, 3'b000} +: GW8];
      bit_sel = '0;
      for (int b = GW8 - 1; b >= 0; b--) begin
         if (!octet[b]) begin
            bit_sel = 3'(b);
         end
      end
      slot_wide = {grp_ff, bit_sel};
   end

   assign slot  = IDX_W'(slot_wide);
   assign found = grp_found_ff;

endmodule

>>> rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator: control, occupancy and result path.
//
// Requests arrive on the req_ channel (valid/ready) with an operation code, a handle
// (index and generation) and the field flag; each request gives exactly one beat on
// the rsp_ channel carrying ok, full_res, the created handle and the active count.
// Create, update, remove and lookup pass through the find, exec and done states,
// paced by the generation memory: find picks the slot and issues the read, exec
// takes the registered read and does the write-back, and done loads the response.
// The block takes a new request only after the previous one has left done.
// Clear all sweeps the generation memory one slot a cycle, with reads and
// write-backs overlapped. After reset the block writes generation 1 into every
// slot, one slot a cycle, with req_ready low; the occupancy map and count clear
// at once. A finished response waits in a holding register while the output
// register is still full, and no new request is accepted meanwhile; a stalled
// receiver stops further progress once that holding register is occupied.
module generational_handle_allocator #(
   parameter int SLOT_COUNT = 64,
   parameter int GEN_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [5:0]  req_handle_index,
   input  logic [15:0] req_handle_generation,
   input  logic        req_field_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic        rsp_full_res,
   output logic [5:0]  rsp_out_index,
   output logic [15:0] rsp_out_generation,
   output logic [5:0]  rsp_active_count
);

   localparam int IW   = ghalloc_pkg::IDX_FIELD_W;
   localparam int GFW  = ghalloc_pkg::GEN_FIELD_W;
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CW   = (IDX_W > IW) ? IDX_W : IW;
   localparam int GX   = (GEN_BITS > GFW) ? GEN_BITS : GFW;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CW:0]      SLOT_LIMIT = (CW + 1)'(SLOT_COUNT);

   function automatic logic [GEN_BITS-1:0] gen_next(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS-1:0] n;
      n = g + 1'b1;
      if (n == '0) begin
         n = GEN_BITS'(1);
      end
      return n;
   endfunction

   ghalloc_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [SLOT_COUNT-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic                  clr_pend_ff, clr_pend_in;
   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;

   logic [2:0]            func_ff;
   logic [IW-1:0]         idx_ff;
   logic [GFW-1:0]        hgen_ff;
   logic                  fok_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic                  found_ff;

   logic                  res_ok_ff, res_ok_in;
   logic                  res_full_ff, res_full_in;
   logic [IW-1:0]         res_idx_ff, res_idx_in;
   logic [GFW-1:0]        res_gen_ff, res_gen_in;
   logic [IW-1:0]         res_cnt_ff, res_cnt_in;
   logic                  res_load;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic                  rsp_full_ff;
   logic [IW-1:0]         rsp_idx_ff;
   logic [GFW-1:0]        rsp_gen_ff;
   logic [IW-1:0]         rsp_cnt_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  out_load;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [GEN_BITS-1:0]   ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [GEN_BITS-1:0]   ram_rdata;

   logic [IDX_W-1:0]      free_slot;
   logic                  free_found;

   logic [CW-1:0]         idx_ext;
   logic [IDX_W-1:0]      idx_sel;
   logic                  in_range;
   logic                  handle_ok;

   ghalloc_ram #(
      .WIDTH (GEN_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ghalloc_search #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_search (
      .clock (clock),
      .occ   (occ_ff),
      .slot  (free_slot),
      .found (free_found)
   );

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign out_load   = (state_ff == ghalloc_pkg::ST_DONE) && out_free;

   assign idx_ext  = CW'(idx_ff);
   assign idx_sel  = idx_ext[IDX_W-1:0];
   assign in_range = (idx_ff != '0) && ({1'b0, idx_ext} < SLOT_LIMIT);
   assign handle_ok = in_range && occ_ff[idx_sel] && (GX'(ram_rdata) == GX'(hgen_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ghalloc_pkg::ST_INIT: begin
            if (sweep_ff == LAST_SLOT) begin
               state_in = ghalloc_pkg::ST_IDLE;
            end
         end
         ghalloc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_func == ghalloc_pkg::FN_CLEAR) begin
                  state_in = ghalloc_pkg::ST_CLEAR;
               end else begin
                  state_in = ghalloc_pkg::ST_FIND;
               end
            end
         end
         ghalloc_pkg::ST_FIND:       state_in = ghalloc_pkg::ST_EXEC;
         ghalloc_pkg::ST_EXEC:       state_in = ghalloc_pkg::ST_DONE;
         ghalloc_pkg::ST_CLEAR: begin
            if (sweep_ff == LAST_SLOT) begin
               state_in = ghalloc_pkg::ST_CLEAR_LAST;
            end
         end
         ghalloc_pkg::ST_CLEAR_LAST: state_in = ghalloc_pkg::ST_DONE;
         ghalloc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ghalloc_pkg::ST_IDLE;
            end
         end
         default:                    state_in = ghalloc_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ram_raddr   = idx_sel;
      clr_pend_in = 1'b0;
      clr_addr_in = sweep_ff;
      sweep_in    = sweep_ff;
      res_load    = 1'b0;
      unique case (state_ff)
         ghalloc_pkg::ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
         end
         ghalloc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            sweep_in  = IDX_W'(1);
         end
         ghalloc_pkg::ST_FIND: begin
            if (func_ff == ghalloc_pkg::FN_CREATE) begin
               ram_raddr = free_slot;
            end
         end
         ghalloc_pkg::ST_EXEC: begin
            res_load = 1'b1;
         end
         ghalloc_pkg::ST_CLEAR: begin
            ram_raddr   = sweep_ff;
            clr_pend_in = occ_ff[sweep_ff];
            sweep_in    = sweep_ff + 1'b1;
         end
         ghalloc_pkg::ST_CLEAR_LAST: begin
            res_load = 1'b1;
         end
         ghalloc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_sel;
      ram_wdata = gen_next(ram_rdata);
      if (state_ff == ghalloc_pkg::ST_INIT) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_ff;
         ram_wdata = GEN_BITS'(1);
      end else if (clr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
      end else if (state_ff == ghalloc_pkg::ST_EXEC && func_ff == ghalloc_pkg::FN_REMOVE &&
                   handle_ok) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      occ_in      = occ_ff;
      count_in    = count_ff;
      res_ok_in   = 1'b0;
      res_full_in = 1'b0;
      res_idx_in  = '0;
      res_gen_in  = '0;
      if (state_ff == ghalloc_pkg::ST_EXEC) begin
         unique case (func_ff)
            ghalloc_pkg::FN_CREATE: begin
               if (fok_ff) begin
                  if (found_ff) begin
                     occ_in[slot_ff] = 1'b1;
                     count_in   = count_ff + 1'b1;
                     res_ok_in  = 1'b1;
                     res_idx_in = IW'(slot_ff);
                     res_gen_in = GFW'(ram_rdata);
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
            end
            ghalloc_pkg::FN_UPDATE: res_ok_in = handle_ok && fok_ff;
            ghalloc_pkg::FN_REMOVE: begin
               if (handle_ok) begin
                  occ_in[idx_sel] = 1'b0;
                  count_in  = count_ff - 1'b1;
                  res_ok_in = 1'b1;
               end
            end
            ghalloc_pkg::FN_LOOKUP: res_ok_in = handle_ok;
            default: begin
            end
         endcase
      end else if (state_ff == ghalloc_pkg::ST_CLEAR_LAST) begin
         occ_in    = '0;
         count_in  = '0;
         res_ok_in = 1'b1;
      end
      res_cnt_in = IW'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ghalloc_pkg::ST_INIT;
         sweep_ff     <= '0;
         occ_ff       <= '0;
         count_ff     <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_addr_ff <= clr_addr_in;
      if (req_accept) begin
         func_ff <= req_func;
         idx_ff  <= req_handle_index;
         hgen_ff <= req_handle_generation;
         fok_ff  <= req_field_ok;
      end
      if (state_ff == ghalloc_pkg::ST_FIND) begin
         slot_ff  <= free_slot;
         found_ff <= free_found;
      end
      if (res_load) begin
         res_ok_ff   <= res_ok_in;
         res_full_ff <= res_full_in;
         res_idx_ff  <= res_idx_in;
         res_gen_ff  <= res_gen_in;
         res_cnt_ff  <= res_cnt_in;
      end
      if (out_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_full_ff <= res_full_ff;
         rsp_idx_ff  <= res_idx_ff;
         rsp_gen_ff  <= res_gen_ff;
         rsp_cnt_ff  <= res_cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_full_res       = rsp_full_ff;
   assign rsp_out_index      = rsp_idx_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_active_count   = rsp_cnt_ff;

   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == int'(count_ff))
      else $error("active count disagrees with the occupancy map");

   a_slot_zero_reserved: assert property (@(posedge clock) disable iff (reset)
      !occ_ff[0])
      else $error("reserved slot zero became occupied");

   a_failed_rsp_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_out_index == '0 && rsp_out_generation == '0))
      else $error("failed response carries a handle");

   a_clear_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_pend_ff |-> $past(state_ff == ghalloc_pkg::ST_CLEAR))
      else $error("clear write-back outside the clear sweep");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 100ps

module tb_top;

   localparam int IDX_W       = ghalloc_pkg::IDX_FIELD_W;
   localparam int GEN_W       = ghalloc_pkg::GEN_FIELD_W;
   localparam int FUNC_W      = ghalloc_pkg::FUNC_FIELD_W;
   localparam int SLOTS       = 1 << IDX_W;
   localparam int FUNC_CODES  = 1 << FUNC_W;
   localparam int IDLE_PCT    = 21;
   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 5000000;

   typedef struct packed {
      logic             ok;
      logic             full_res;
      logic [IDX_W-1:0] index;
      logic [GEN_W-1:0] generation;
      logic [IDX_W-1:0] active;
   } alloc_reply_type;

   logic              clock;
   logic              reset                 = 1'b1;
   logic              req_valid             = 1'b0;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func              = '0;
   logic [IDX_W-1:0]  req_handle_index      = '0;
   logic [GEN_W-1:0]  req_handle_generation = '0;
   logic              req_field_ok          = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready             = 1'b0;
   logic              rsp_ok;
   logic              rsp_full_res;
   logic [IDX_W-1:0]  rsp_out_index;
   logic [GEN_W-1:0]  rsp_out_generation;
   logic [IDX_W-1:0]  rsp_active_count;

   logic              slot_busy [SLOTS];
   logic [GEN_W-1:0]  slot_gen [SLOTS];
   logic [IDX_W-1:0]  busy_total;

   alloc_reply_type   pending_replies [$];
   alloc_reply_type   want_reply;
   int                mismatches   = 0;
   int                cycle_count  = 0;
   int                hold_left    = 0;
   bit                hold_pending = 1'b0;
   bit                steady       = 1'b0;

   generational_handle_allocator i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .req_field_ok          (req_field_ok),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_ok                (rsp_ok),
      .rsp_full_res          (rsp_full_res),
      .rsp_out_index         (rsp_out_index),
      .rsp_out_generation    (rsp_out_generation),
      .rsp_active_count      (rsp_active_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void retire_slot(input int s);
      logic [GEN_W-1:0] g;
      g = slot_gen[s] + 1'b1;
      slot_gen[s]  = (g == '0) ? GEN_W'(1) : g;
      slot_busy[s] = 1'b0;
      if (busy_total != '0) busy_total--;
   endfunction

   function automatic alloc_reply_type predict_reply(input logic [FUNC_W-1:0] fn,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [GEN_W-1:0] g,
                                                     input logic fok);
      alloc_reply_type r;
      int              s;
      logic            hit;
      r   = '0;
      hit = (idx != '0) && slot_busy[idx] && (slot_gen[idx] == g);
      case (fn)
         ghalloc_pkg::FN_CREATE: begin
            if (fok) begin
               s = 1;
               while (s < SLOTS && slot_busy[s]) s++;
               if (s == SLOTS) begin
                  r.full_res = 1'b1;
               end else begin
                  slot_busy[s] = 1'b1;
                  busy_total++;
                  r.ok         = 1'b1;
                  r.index      = IDX_W'(s);
                  r.generation = slot_gen[s];
               end
            end
         end
         ghalloc_pkg::FN_UPDATE: r.ok = hit && fok;
         ghalloc_pkg::FN_REMOVE: begin
            if (hit) begin
               retire_slot(idx);
               r.ok = 1'b1;
            end
         end
         ghalloc_pkg::FN_LOOKUP: r.ok = hit;
         ghalloc_pkg::FN_CLEAR: begin
            for (s = 1; s < SLOTS; s++)
               if (slot_busy[s]) retire_slot(s);
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.active = busy_total;
      return r;
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Sends one request beat and records the reply it must produce.
   task automatic send_request(input logic [FUNC_W-1:0] fn,
                               input logic [IDX_W-1:0] idx,
                               input logic [GEN_W-1:0] g,
                               input logic fok);
      int gap;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid             <= 1'b1;
      req_func              <= fn;
      req_handle_index      <= idx;
      req_handle_generation <= g;
      req_field_ok          <= fok;
      do @(posedge clock); while (!req_ready);
      pending_replies.insert(pending_replies.size(), predict_reply(fn, idx, g, fok));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            $error("reply beat arrived with none pending");
         end else begin
            want_reply = pending_replies.pop_front();
            compare_field("ok", want_reply.ok, rsp_ok);
            compare_field("full_res", want_reply.full_res, rsp_full_res);
            compare_field("out_index", want_reply.index, rsp_out_index);
            compare_field("out_generation", want_reply.generation, rsp_out_generation);
            compare_field("active_count", want_reply.active, rsp_active_count);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic test_idle_table();
      int c;
      send_request(ghalloc_pkg::FN_LOOKUP, '0, '0, 1'b1);
      send_request(ghalloc_pkg::FN_LOOKUP, 6'd1, 16'd1, 1'b1);
      send_request(ghalloc_pkg::FN_UPDATE, 6'd1, 16'd1, 1'b1);
      send_request(ghalloc_pkg::FN_REMOVE, 6'd1, 16'd1, 1'b1);
      send_request(ghalloc_pkg::FN_CLEAR, '0, '0, 1'b0);
      for (c = ghalloc_pkg::FN_CLEAR + 1; c < FUNC_CODES; c++)
         send_request(FUNC_W'(c), '1, '1, 1'b1);
   endtask

   task automatic test_create_and_retire();
      send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b0);
      send_request(ghalloc_pkg::FN_CREATE, '1, '1, 1'b1);
      send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
      send_request(ghalloc_pkg::FN_UPDATE, 6'd1, slot_gen[1], 1'b1);
      send_request(ghalloc_pkg::FN_UPDATE, 6'd1, slot_gen[1], 1'b0);
      send_request(ghalloc_pkg::FN_LOOKUP, 6'd1, slot_gen[1], 1'b0);
      send_request(ghalloc_pkg::FN_LOOKUP, 6'd2, slot_gen[2] ^ 16'h8000, 1'b1);
      send_request(ghalloc_pkg::FN_REMOVE, 6'd1, slot_gen[1], 1'b1);
      send_request(ghalloc_pkg::FN_LOOKUP, 6'd1, slot_gen[1] - 1'b1, 1'b1);
      send_request(ghalloc_pkg::FN_REMOVE, 6'd1, slot_gen[1] - 1'b1, 1'b1);
      send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
   endtask

   task automatic test_full_table();
      logic [GEN_W-1:0] old_gen;
      int               n;
      send_request(ghalloc_pkg::FN_CLEAR, '0, '0, 1'b1);
      for (n = 1; n < SLOTS; n++)
         send_request(ghalloc_pkg::FN_CREATE, IDX_W'(n), '0, 1'b1);
      send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
      send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b0);
      send_request(ghalloc_pkg::FN_LOOKUP, '1, slot_gen[SLOTS-1], 1'b1);
      send_request(ghalloc_pkg::FN_LOOKUP, '1, '1, 1'b1);
      old_gen = slot_gen[SLOTS-1];
      send_request(ghalloc_pkg::FN_CLEAR, '0, '0, 1'b1);
      send_request(ghalloc_pkg::FN_LOOKUP, '1, old_gen, 1'b1);
      send_request(ghalloc_pkg::FN_CLEAR, '0, '0, 1'b1);
   endtask

   task automatic test_backpressure();
      int n;
      hold_pending = 1'b1;
      for (n = 0; n < 6; n++)
         send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
      for (n = 1; n <= 6; n++)
         send_request((n % 2) ? ghalloc_pkg::FN_LOOKUP : ghalloc_pkg::FN_REMOVE,
                      IDX_W'(n), slot_gen[n], 1'b1);
   endtask

   // Recycles slot 1 repeatedly with its current generation, so that each remove bumps it.
   task automatic test_generation_churn();
      int n;
      steady = 1'b1;
      send_request(ghalloc_pkg::FN_CLEAR, '0, '0, 1'b1);
      for (n = 0; n < 20; n++) begin
         send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
         send_request(ghalloc_pkg::FN_REMOVE, 6'd1, slot_gen[1], 1'b1);
      end
      for (n = 0; n < 2; n++) begin
         send_request(ghalloc_pkg::FN_CREATE, '0, '0, 1'b1);
         send_request(ghalloc_pkg::FN_LOOKUP, 6'd1, slot_gen[1], 1'b1);
         send_request(ghalloc_pkg::FN_REMOVE, 6'd1, slot_gen[1], 1'b1);
      end
      steady = 1'b0;
   endtask

   function automatic logic [IDX_W-1:0] pick_live_slot();
      int live [$];
      int s;
      for (s = 1; s < SLOTS; s++)
         if (slot_busy[s]) live.insert(live.size(), s);
      if (live.size() == 0) return IDX_W'($urandom_range(1, SLOTS - 1));
      return IDX_W'(live[$urandom_range(live.size() - 1)]);
   endfunction

   task automatic test_random_traffic(input int count);
      int                n;
      int                pick;
      logic [FUNC_W-1:0] fn;
      logic [IDX_W-1:0]  idx;
      logic [GEN_W-1:0]  g;
      logic              fok;
      for (n = 0; n < count; n++) begin
         steady = (n >= count / 3) && (n < count / 3 + 150);
         pick   = $urandom_range(99);
         fok    = ($urandom_range(9) != 0);
         idx    = pick_live_slot();
         g      = slot_gen[idx];
         if (pick < 35) begin
            fn = ghalloc_pkg::FN_CREATE;
         end else if (pick < 55) begin
            fn = ghalloc_pkg::FN_REMOVE;
         end else if (pick < 70) begin
            fn = ghalloc_pkg::FN_LOOKUP;
         end else if (pick < 82) begin
            fn = ghalloc_pkg::FN_UPDATE;
         end else if (pick < 84) begin
            fn = ghalloc_pkg::FN_CLEAR;
         end else if (pick < 92) begin
            fn = FUNC_W'($urandom_range(ghalloc_pkg::FN_UPDATE, ghalloc_pkg::FN_LOOKUP));
            g  = g ^ GEN_W'(1 << $urandom_range(GEN_W - 1));
         end else begin
            fn  = FUNC_W'($urandom_range(FUNC_CODES - 1));
            idx = IDX_W'($urandom);
            g   = GEN_W'($urandom);
         end
         send_request(fn, idx, g, fok);
      end
      steady = 1'b0;
   endtask

   initial begin
      int s;
      for (s = 0; s < SLOTS; s++) begin
         slot_busy[s] = 1'b0;
         slot_gen[s]  = GEN_W'(1);
      end
      busy_total = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_table();
      test_create_and_retire();
      test_full_table();
      test_backpressure();
      test_generation_churn();
      test_random_traffic(800);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2 * SLOTS) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> generational_handle_allocator.f
rtl/ghalloc_pkg.sv
rtl/ghalloc_ram.sv
rtl/ghalloc_search.sv
rtl/generational_handle_allocator.sv
sim/tb_top.sv
